FILE: rtl/hrlp_pkg.sv
// hrlp_pkg: types, character codes and the host-side parse step of the
// http request line parser; no dependencies
package hrlp_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 3;
    localparam int PORT_W      = 16;
    localparam int PREFIX_LEN  = 6;
    localparam int CNT_W       = 3;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;

    localparam logic [PORT_W-1:0] PORT_MAX         = 16'hFFFF;
    localparam logic [PORT_W-1:0] DEFAULT_PORT_RST = 16'd80;

    localparam logic [2:0] TAG_NONE    = 3'd0;
    localparam logic [2:0] TAG_METHOD  = 3'd1;
    localparam logic [2:0] TAG_HOST    = 3'd2;
    localparam logic [2:0] TAG_PATH    = 3'd3;
    localparam logic [2:0] TAG_VERSION = 3'd4;

    // field_nonempty and error_marks bit positions
    localparam int NE_METHOD = 0;
    localparam int NE_HOST   = 1;
    localparam int NE_PATH   = 2;
    localparam int ERR_PORT  = 1;

    typedef enum logic [7:0] {
        PH_METHOD  = 8'b0000_0001,
        PH_PREFIX  = 8'b0000_0010,
        PH_SKIP    = 8'b0000_0100,
        PH_HOST    = 8'b0000_1000,
        PH_PORT    = 8'b0001_0000,
        PH_PATH    = 8'b0010_0000,
        PH_VERSION = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic [PORT_W-1:0] acc;
        logic              port_seen;
        logic [2:0]        nonempty;
        logic [1:0]        errs;
    } state_t;

    typedef struct packed {
        state_t     st;
        logic       push;
        logic [2:0] tag;
    } step_t;

    localparam state_t ST_RESET = '{phase: PH_METHOD, acc: 16'd0, port_seen: 1'b0,
                                    nonempty: 3'b000, errs: 2'b00};

    // expected prefix after the method: "http:/"
    function automatic logic [7:0] prefix_char(input logic [CNT_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h68;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h70;
            3'd4:    c = 8'h3A;
            3'd5:    c = 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // one byte through the host / port / path / version phases
    function automatic step_t host_step(input state_t s, input logic [7:0] b);
        step_t       r;
        logic [19:0] v;
        logic        is_digit;
        r        = '{st: s, push: 1'b0, tag: TAG_NONE};
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        // acc * 10 + digit, digit is the low nibble of an ascii digit
        v = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0} + {16'd0, b[3:0]};
        unique case (s.phase)
            PH_HOST:
            begin
                if (b == CH_SLASH)
                begin
                    r.st.phase = PH_PATH;
                    r.st.nonempty[NE_PATH] = 1'b1;
                    r.push = 1'b1;
                    r.tag  = TAG_PATH;
                end
                else if (b == CH_COLON)
                begin
                    r.st.phase = PH_PORT;
                    r.st.port_seen = 1'b1;
                end
                else
                begin
                    r.st.nonempty[NE_HOST] = 1'b1;
                    r.push = 1'b1;
                    r.tag  = TAG_HOST;
                end
            end
            PH_PORT:
            begin
                if (b == CH_SLASH)
                begin
                    r.st.phase = PH_PATH;
                    r.st.nonempty[NE_PATH] = 1'b1;
                    r.push = 1'b1;
                    r.tag  = TAG_PATH;
                end
                else if (b == CH_SPACE)
                begin
                    r.st.phase = PH_VERSION;
                end
                else if (is_digit)
                begin
                    if (v[19:16] != 4'd0)
                    begin
                        r.st.acc = PORT_MAX;
                        r.st.errs[ERR_PORT] = 1'b1;
                    end
                    else
                    begin
                        r.st.acc = v[15:0];
                    end
                end
                else
                begin
                    r.st.errs[ERR_PORT] = 1'b1;
                end
            end
            PH_PATH:
            begin
                if (b == CH_SPACE)
                begin
                    r.st.phase = PH_VERSION;
                end
                else
                begin
                    r.st.nonempty[NE_PATH] = 1'b1;
                    r.push = 1'b1;
                    r.tag  = TAG_PATH;
                end
            end
            PH_VERSION:
            begin
                if ((b == CH_CR) || (b == CH_LF))
                begin
                    r.st.phase = PH_DONE;
                end
                else
                begin
                    r.push = 1'b1;
                    r.tag  = TAG_VERSION;
                end
            end
            default:
            begin
                r.push = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/http_request_line_parser.sv
// http_request_line_parser: tags the bytes of an http request line
// depends on hrlp_pkg (types, character codes, host parse step)
//
// usage
//   s_* carries one request byte per beat, s_tlast marks the last byte of a
//   request. m_* carries one result per beat; m_tlast marks the final result
//   caused by an input byte, m_tuser holds the field tag. on the final result
//   of the last byte, m_tdata also holds the summary (request_done set).
//   cfg_* writes default_port; write it only while the block is idle.
// timing
//   an input beat goes into an input register and its result leaves from a
//   result register; one byte per cycle sustained while m_tready is high and no replay runs.
//   when the "http:/" check fails, or the request ends inside it, the held
//   n bytes (n up to 6) are replayed one per cycle while m_tready allows,
//   then a flush step; the input register still takes one beat.
// reset
//   rst_n clears the parse state, the valid bits of both registers and default_port (to 80).
// stalls
//   with m_tready low the result register holds; the input register then
//   takes a beat only if it is empty, and s_tready stays low while it is full.
module http_request_line_parser
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [hrlp_pkg::IN_TDATA_W-1:0]  s_tdata,   // data_byte
    input  logic                             s_tlast,   // end_of_request
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // field_byte, byte_valid, request_done, port_number, format_error,
    // port_error, request_ok, zero fill
    output logic [hrlp_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast,   // last_of_run
    output logic [hrlp_pkg::OUT_TUSER_W-1:0] m_tuser,   // field_tag
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hrlp_pkg::PORT_W-1:0]      cfg_data   // default_port
);
    import hrlp_pkg::*;

    // input register
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;

    // parse state
    state_t           st_reg, st_next;
    logic [CNT_W-1:0] pcount_reg, pcount_next;
    logic [PORT_W-1:0] default_port_reg;

    // replay sequencer
    logic             rp_active_reg, rp_active_next;
    logic [CNT_W-1:0] rp_idx_reg, rp_idx_next;
    logic [CNT_W-1:0] rp_n_reg, rp_n_next;
    logic [7:0]       rp_fin_reg, rp_fin_next;
    logic             rp_last_reg, rp_last_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [2:0]       pend_tag_reg, pend_tag_next;
    logic [7:0]       pend_byte_reg, pend_byte_next;

    // result register
    logic             out_valid_reg;
    logic [2:0]       out_tag_reg;
    logic [7:0]       out_byte_reg;
    logic             out_bvalid_reg;
    logic             out_last_reg;
    logic             out_done_reg;
    logic [PORT_W-1:0] out_port_reg;
    logic             out_ferr_reg;
    logic             out_perr_reg;
    logic             out_ok_reg;

    logic             out_free, go_in, go_rp;
    logic             rp_final, rp_flush;
    logic [7:0]       rp_byte, step_b;
    step_t            hs;

    state_t           top_st;
    logic [CNT_W-1:0] top_pcount;
    logic             top_push;
    logic [2:0]       top_tag;
    logic             start_rp;

    logic             emit, e_valid, e_last, e_done;
    logic [2:0]       e_tag;
    logic [7:0]       e_byte;
    state_t           sum_st;
    logic [PORT_W-1:0] sum_port;
    logic             sum_ferr, sum_perr, sum_ok;

    assign out_free  = !out_valid_reg || m_tready;
    assign go_in     = in_valid_reg && !rp_active_reg && out_free;
    assign go_rp     = rp_active_reg && out_free;
    assign s_tready  = !in_valid_reg || go_in;
    assign cfg_ready = 1'b1;

    assign rp_flush = (rp_idx_reg == rp_n_reg);
    assign rp_final = (rp_idx_reg == (rp_n_reg - 3'd1));
    // held bytes matched the pattern, only the last one may differ
    assign rp_byte  = rp_final ? rp_fin_reg : prefix_char(rp_idx_reg);
    assign step_b   = rp_active_reg ? rp_byte : in_byte_reg;
    assign hs       = host_step(st_reg, step_b);

    // method, prefix and skip phases; later phases go to the host step
    always_comb
    begin
        top_st     = st_reg;
        top_pcount = pcount_reg;
        top_push   = 1'b0;
        top_tag    = TAG_NONE;
        start_rp   = 1'b0;
        unique case (st_reg.phase)
            PH_METHOD:
            begin
                if (in_byte_reg == CH_SPACE)
                begin
                    top_st.phase = PH_PREFIX;
                    top_pcount   = '0;
                end
                else
                begin
                    top_st.nonempty[NE_METHOD] = 1'b1;
                    top_push = 1'b1;
                    top_tag  = TAG_METHOD;
                end
            end
            PH_PREFIX:
            begin
                if ((in_byte_reg != prefix_char(pcount_reg)) ||
                    (in_last_reg && (pcount_reg != CNT_W'(PREFIX_LEN - 1))))
                begin
                    start_rp     = 1'b1;
                    top_st.phase = PH_HOST;
                    top_pcount   = '0;
                end
                else if (pcount_reg == CNT_W'(PREFIX_LEN - 1))
                begin
                    top_st.phase = PH_SKIP;
                    top_pcount   = '0;
                end
                else
                begin
                    top_pcount = pcount_reg + 3'd1;
                end
            end
            PH_SKIP:
            begin
                top_st.phase = PH_HOST;
            end
            default:
            begin
                top_st   = hs.st;
                top_push = hs.push;
                top_tag  = hs.tag;
            end
        endcase
    end

    always_comb
    begin
        st_next         = st_reg;
        pcount_next     = pcount_reg;
        rp_active_next  = rp_active_reg;
        rp_idx_next     = rp_idx_reg;
        rp_n_next       = rp_n_reg;
        rp_fin_next     = rp_fin_reg;
        rp_last_next    = rp_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_tag_next   = pend_tag_reg;
        pend_byte_next  = pend_byte_reg;
        emit    = 1'b0;
        e_valid = 1'b0;
        e_tag   = TAG_NONE;
        e_byte  = 8'd0;
        e_last  = 1'b0;
        e_done  = 1'b0;
        sum_st  = st_reg;
        if (go_in)
        begin
            st_next     = top_st;
            pcount_next = top_pcount;
            if (start_rp)
            begin
                rp_active_next  = 1'b1;
                rp_idx_next     = '0;
                rp_n_next       = pcount_reg + 3'd1;
                rp_fin_next     = in_byte_reg;
                rp_last_next    = in_last_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                emit    = 1'b1;
                e_valid = top_push;
                e_tag   = top_tag;
                e_byte  = in_byte_reg;
                e_last  = 1'b1;
                e_done  = in_last_reg;
                sum_st  = top_st;
            end
        end
        else if (go_rp)
        begin
            if (rp_flush)
            begin
                // the last pending byte closes the run; it carries the summary if the request ended
                rp_active_next = 1'b0;
                emit    = 1'b1;
                e_valid = pend_valid_reg;
                e_tag   = pend_tag_reg;
                e_byte  = pend_byte_reg;
                e_last  = 1'b1;
                e_done  = rp_last_reg;
                sum_st  = st_reg;
            end
            else
            begin
                st_next     = hs.st;
                rp_idx_next = rp_idx_reg + 3'd1;
                if (hs.push)
                begin
                    pend_valid_next = 1'b1;
                    pend_tag_next   = hs.tag;
                    pend_byte_next  = step_b;
                    if (pend_valid_reg)
                    begin
                        emit    = 1'b1;
                        e_valid = 1'b1;
                        e_tag   = pend_tag_reg;
                        e_byte  = pend_byte_reg;
                    end
                end
            end
        end
        if (emit && e_done)
        begin
            st_next     = ST_RESET;
            pcount_next = '0;
        end
    end

    assign sum_port = sum_st.port_seen ? sum_st.acc : default_port_reg;
    assign sum_ferr = !((sum_st.phase == PH_VERSION) || (sum_st.phase == PH_DONE));
    assign sum_perr = sum_st.errs[ERR_PORT];
    assign sum_ok   = (&sum_st.nonempty) && (sum_port != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            st_reg           <= ST_RESET;
            pcount_reg       <= '0;
            default_port_reg <= DEFAULT_PORT_RST;
            rp_active_reg    <= 1'b0;
            rp_idx_reg       <= '0;
            rp_n_reg         <= '0;
            rp_last_reg      <= 1'b0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (cfg_valid && cfg_ready)
            begin
                default_port_reg <= cfg_data;
            end
            st_reg         <= st_next;
            pcount_reg     <= pcount_next;
            rp_active_reg  <= rp_active_next;
            rp_idx_reg     <= rp_idx_next;
            rp_n_reg       <= rp_n_next;
            rp_last_reg    <= rp_last_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= emit || (out_valid_reg && !m_tready);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        rp_fin_reg    <= rp_fin_next;
        pend_tag_reg  <= pend_tag_next;
        pend_byte_reg <= pend_byte_next;
        if (emit)
        begin
            out_tag_reg    <= e_valid ? e_tag : TAG_NONE;
            out_byte_reg   <= e_valid ? e_byte : 8'd0;
            out_bvalid_reg <= e_valid;
            out_last_reg   <= e_last;
            out_done_reg   <= e_done;
            out_port_reg   <= e_done ? sum_port : '0;
            out_ferr_reg   <= e_done && sum_ferr;
            out_perr_reg   <= e_done && sum_perr;
            out_ok_reg     <= e_done && sum_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_tag_reg;
    assign m_tdata  = {3'b000, out_ok_reg, out_perr_reg, out_ferr_reg, out_port_reg,
                       out_done_reg, out_bvalid_reg, out_byte_reg};

    // replay index never runs past the flush step
    a_rp_idx: assert property (@(posedge clk) disable iff (!rst_n)
        rp_active_reg |-> (rp_idx_reg <= rp_n_reg))
        else $error("replay index beyond held count");

    // a finished request leaves the parser in the method phase
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && e_done) |=> (st_reg.phase == PH_METHOD) && (pcount_reg == '0))
        else $error("state not cleared after request end");

    // the summary only rides on the final result of a run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_done_reg) |-> m_tlast)
        else $error("summary on a result that is not last of run");

    // a replay starts with no pending byte and blocks the input register
    a_rp_start: assert property (@(posedge clk) disable iff (!rst_n)
        (go_in && start_rp) |=> (rp_active_reg && !pend_valid_reg && !go_in))
        else $error("replay start left stale pending byte");

    // empty results carry no tag
    a_empty_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_bvalid_reg) |-> (m_tuser == TAG_NONE))
        else $error("tag set on result without a byte");

endmodule
